@@ rtl/two_list_sorted_merge_defines.svh @@
// Assertion macros shared by the sorted-merge RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TWO_LIST_SORTED_MERGE_DEFINES_SVH
`define TWO_LIST_SORTED_MERGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLSM_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
    else $error("sorted merge assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLSM_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
    else $error("sorted merge assertion failed");

`endif

@@ rtl/tlsm_pkg.sv @@
// Types and constants for the two-list sorted merge block.
// No dependencies; imported by tlsm_head_sel and two_list_sorted_merge.
package tlsm_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Outcome of one head comparison: which list supplies the next element.
  typedef struct packed {
    logic   take_a;
    value_t value;
  } head_pick_t;

endpackage

@@ rtl/tlsm_head_sel.sv @@
// Shared compare-and-select unit: picks the next merged element from two heads.
// Depends on tlsm_pkg.
module tlsm_head_sel
  import tlsm_pkg::*;
(
  input  logic       a_avail,
  input  logic       b_avail,
  input  value_t     a_head,
  input  value_t     b_head,
  output head_pick_t pick
);

  logic a_less;

  // Signed compare; a tie sends the B head first.
  assign a_less = (a_head < b_head);

  // Once one list is exhausted, the other one drains.
  always_comb begin
    pick.take_a = a_avail && (!b_avail || a_less);
    pick.value  = pick.take_a ? a_head : b_head;
  end

endmodule

@@ rtl/two_list_sorted_merge.sv @@
// Two-list sorted merge. After the final load item the sequencer enters the
// merge state, and each merged result is registered and then strobed out.
// Throughput: one load item per cycle, then busy stays high while one result
// per cycle leaves until the stored total is emitted; the single compare-
// select unit sets that rate. The receiver cannot stall the result strobe.
// Reset (synchronous, rst_n low) clears counts, head indices, drop flag, strobe, run-end flag and sequencer.
`include "two_list_sorted_merge_defines.svh"

module two_list_sorted_merge
  import tlsm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  logic   in_list_select,
  input  value_t in_value,
  input  logic   in_final_item,
  output logic   out_strobe,
  output value_t out_merged_value,
  output logic   out_run_last,
  output logic   out_overflowed
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  typedef enum logic {ST_LOAD, ST_MERGE} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_a_r, cnt_b_r;
  logic [CNT_W-1:0] idx_a_r, idx_b_r;
  logic             drop_r;
  logic             strobe_r;
  logic             run_last_r;
  value_t           merged_r;
  logic             ovf_r;

  value_t     store_a [LIST_DEPTH];
  value_t     store_b [LIST_DEPTH];

  logic       accept;
  logic       a_full, b_full;
  logic       a_avail, b_avail;
  value_t     a_head, b_head;
  head_pick_t pick;
  logic       last_nxt;
  logic [SUM_W-1:0] done_cnt, total_cnt;

  assign busy   = (state_r == ST_MERGE);
  assign accept = start && !busy;
  assign a_full = (cnt_a_r == DEPTH_C);
  assign b_full = (cnt_b_r == DEPTH_C);

  // List storage: one append per transfer, no reset on contents.
  always_ff @(posedge clk) begin
    if (accept && !in_list_select && !a_full) begin
      store_a[cnt_a_r[IDX_W-1:0]] <= in_value;
    end
    if (accept && in_list_select && !b_full) begin
      store_b[cnt_b_r[IDX_W-1:0]] <= in_value;
    end
  end

  // Heads of both lists as seen by the compare unit.
  assign a_avail = (idx_a_r < cnt_a_r);
  assign b_avail = (idx_b_r < cnt_b_r);
  assign a_head  = store_a[idx_a_r[IDX_W-1:0]];
  assign b_head  = store_b[idx_b_r[IDX_W-1:0]];

  tlsm_head_sel u_head_sel (
    .a_avail (a_avail),
    .b_avail (b_avail),
    .a_head  (a_head),
    .b_head  (b_head),
    .pick    (pick)
  );

  // The element being emitted is the last when it completes the total.
  assign done_cnt  = SUM_W'(idx_a_r) + SUM_W'(idx_b_r) + SUM_W'(1);
  assign total_cnt = SUM_W'(cnt_a_r) + SUM_W'(cnt_b_r);
  assign last_nxt  = (done_cnt == total_cnt);

  // Sequencer with counts, head indices and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      idx_a_r    <= '0;
      idx_b_r    <= '0;
      drop_r     <= 1'b0;
      strobe_r   <= 1'b0;
      run_last_r <= 1'b0;
    end else begin
      strobe_r   <= 1'b0;
      run_last_r <= 1'b0;
      case (state_r)
        ST_LOAD: begin
          if (accept) begin
            if (!in_list_select) begin
              if (a_full) begin
                drop_r <= 1'b1;
              end else begin
                cnt_a_r <= cnt_a_r + CNT_W'(1);
              end
            end else begin
              if (b_full) begin
                drop_r <= 1'b1;
              end else begin
                cnt_b_r <= cnt_b_r + CNT_W'(1);
              end
            end
            if (in_final_item) begin
              idx_a_r <= '0;
              idx_b_r <= '0;
              state_r <= ST_MERGE;
            end
          end
        end
        ST_MERGE: begin
          strobe_r   <= 1'b1;
          run_last_r <= last_nxt;
          merged_r   <= pick.value;
          ovf_r      <= drop_r;
          if (pick.take_a) begin
            idx_a_r <= idx_a_r + CNT_W'(1);
          end else begin
            idx_b_r <= idx_b_r + CNT_W'(1);
          end
          if (last_nxt) begin
            cnt_a_r <= '0;
            cnt_b_r <= '0;
            drop_r  <= 1'b0;
            state_r <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_strobe       = strobe_r;
  assign out_merged_value = merged_r;
  assign out_run_last     = run_last_r;
  assign out_overflowed   = ovf_r;

  // Every merge cycle produces exactly one result transfer.
  `TLSM_ASSERT_NXT(a_merge_strobes, clk, rst_n, state_r == ST_MERGE, strobe_r)
  // The run-end marker only travels with a result.
  `TLSM_ASSERT_IMP(a_last_with_strobe, clk, rst_n, run_last_r, strobe_r)
  // Head indices never run past the stored counts while merging.
  `TLSM_ASSERT_IMP(a_idx_bound, clk, rst_n, state_r == ST_MERGE,
                   idx_a_r <= cnt_a_r && idx_b_r <= cnt_b_r)
  // After the final result the block is idle with empty lists.
  `TLSM_ASSERT_IMP(a_run_clears, clk, rst_n, strobe_r && run_last_r,
                   !busy && cnt_a_r == '0 && cnt_b_r == '0 && !drop_r)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for two_list_sorted_merge: directed loads, then random runs.
// Depends on tlsm_pkg and the two_list_sorted_merge RTL only.
module tb;
  import tlsm_pkg::*;

  localparam int unsigned DEPTH          = 8;
  localparam int unsigned RANDOM_ITEMS   = 250;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam logic        LIST_A         = 1'b0;
  localparam logic        LIST_B         = 1'b1;

  // One merged element as it leaves the block.
  typedef struct packed {
    value_t value;
    logic   last;
    logic   ovf;
  } merged_elem_t;

  // One load transfer, with an optional hand-written expectation.
  typedef struct packed {
    logic         sel;
    value_t       value;
    logic         fin;
    logic         typed;
    merged_elem_t want;
  } load_row_t;

  logic   clk            = 1'b0;
  logic   rst_n          = 1'b0;
  logic   start          = 1'b0;
  logic   busy;
  logic   in_list_select = 1'b0;
  value_t in_value       = '0;
  logic   in_final_item  = 1'b0;
  logic   out_strobe;
  value_t out_merged_value;
  logic   out_run_last;
  logic   out_overflowed;

  load_row_t cur_row = '0;

  // Local copy of the two lists and the drop flag.
  value_t list_a_mem [DEPTH];
  value_t list_b_mem [DEPTH];
  int unsigned list_a_len = 0;
  int unsigned list_b_len = 0;
  logic        dropped    = 1'b0;

  merged_elem_t fresh_run  [$];
  merged_elem_t merged_due [$];
  load_row_t    rows       [$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          no_idle = 1'b0;

  two_list_sorted_merge #(
    .LIST_DEPTH(DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_list_select  (in_list_select),
    .in_value        (in_value),
    .in_final_item   (in_final_item),
    .out_strobe      (out_strobe),
    .out_merged_value(out_merged_value),
    .out_run_last    (out_run_last),
    .out_overflowed  (out_overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Appends one value to its list and, on the final item, builds the merged run.
  function automatic void load_and_merge(input logic sel, input value_t v, input logic fin);
    int unsigned i;
    int unsigned j;
    int unsigned total;
    merged_elem_t e;
    fresh_run.delete();
    if (sel == LIST_A) begin
      if (list_a_len < DEPTH) begin
        list_a_mem[list_a_len] = v;
        list_a_len++;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      if (list_b_len < DEPTH) begin
        list_b_mem[list_b_len] = v;
        list_b_len++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (!fin) return;
    total = list_a_len + list_b_len;
    i = 0;
    j = 0;
    for (int unsigned n = 0; n < total; n++) begin
      // The first list wins only when strictly smaller; ties go to the second.
      if (i < list_a_len && (j >= list_b_len || list_a_mem[i] < list_b_mem[j])) begin
        e.value = list_a_mem[i];
        i++;
      end else begin
        e.value = list_b_mem[j];
        j++;
      end
      e.last = (n + 1 == total);
      e.ovf  = dropped;
      fresh_run.push_back(e);
    end
    list_a_len = 0;
    list_b_len = 0;
    dropped    = 1'b0;
  endfunction

  function automatic void dir_row(input logic sel, input value_t v, input logic fin,
                                  input logic typed, input merged_elem_t want);
    load_row_t r;
    r.sel   = sel;
    r.value = v;
    r.fin   = fin;
    r.typed = typed;
    r.want  = want;
    rows.push_back(r);
  endfunction

  // Either any 32-bit pattern or a value near zero, so that ties are common.
  function automatic value_t pick_value(input bit wide);
    if (wide) return value_t'($urandom);
    return value_t'(int'($urandom_range(0, 8)) - 4);
  endfunction

  // Offers one load transfer, after a random gap when a burst has run out.
  task automatic send_row(input load_row_t r);
    if (!no_idle && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    start          <= 1'b1;
    in_list_select <= r.sel;
    in_value       <= r.value;
    in_final_item  <= r.fin;
    cur_row        <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Prediction on each accepted transfer, checking of each strobed result, watchdog.
  always @(posedge clk) begin
    merged_elem_t got;
    merged_elem_t want;
    if (rst_n) begin
      if (start && !busy) begin
        load_and_merge(in_list_select, in_value, in_final_item);
        if (cur_row.typed) begin
          merged_due.push_back(cur_row.want);
        end else begin
          foreach (fresh_run[k]) merged_due.push_back(fresh_run[k]);
        end
      end
      if (out_strobe) begin
        got.value = out_merged_value;
        got.last  = out_run_last;
        got.ovf   = out_overflowed;
        if (merged_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %0d", got.value));
        end else begin
          want = merged_due.pop_front();
          if (got.value !== want.value)
            flag_mismatch($sformatf("merged_value %0d, expected %0d", got.value, want.value));
          if (got.last !== want.last)
            flag_mismatch($sformatf("run_last %b, expected %b", got.last, want.last));
          if (got.ovf !== want.ovf)
            flag_mismatch($sformatf("overflowed %b, expected %b", got.ovf, want.ovf));
        end
      end
    end
    if ((start && !busy) || out_strobe) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus: reset, directed table, random runs, then drain.
  initial begin
    int unsigned sent;
    int unsigned cap;
    int unsigned na;
    int unsigned nb;
    bit          noise;
    bit          wide;
    value_t      qa [$];
    value_t      qb [$];
    load_row_t   r;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the value field and minus one, each as a one-element run.
    dir_row(LIST_A, 32'sh7fffffff, 1'b1, 1'b1, '{32'sh7fffffff, 1'b1, 1'b0});
    dir_row(LIST_B, 32'sh80000000, 1'b1, 1'b1, '{32'sh80000000, 1'b1, 1'b0});
    dir_row(LIST_A, -32'sd1, 1'b1, 1'b1, '{-32'sd1, 1'b1, 1'b0});
    // Equal heads in both lists.
    dir_row(LIST_A, 32'sd5, 1'b0, 1'b0, '0);
    dir_row(LIST_B, 32'sd5, 1'b1, 1'b0, '0);
    // An ordinary interleaved merge with a negative tie.
    dir_row(LIST_A, -32'sd3, 1'b0, 1'b0, '0);
    dir_row(LIST_B, -32'sd3, 1'b0, 1'b0, '0);
    dir_row(LIST_B, 32'sd2, 1'b0, 1'b0, '0);
    dir_row(LIST_A, 32'sd7, 1'b0, 1'b0, '0);
    dir_row(LIST_B, 32'sd9, 1'b1, 1'b0, '0);
    // Unsorted input in the first list.
    dir_row(LIST_A, 32'sd10, 1'b0, 1'b0, '0);
    dir_row(LIST_A, -32'sd10, 1'b0, 1'b0, '0);
    dir_row(LIST_B, 32'sd0, 1'b1, 1'b0, '0);
    // Fill the first list, then drop the final item itself.
    for (int k = 1; k <= DEPTH; k++) dir_row(LIST_A, value_t'(k), 1'b0, 1'b0, '0);
    dir_row(LIST_A, 32'sd100, 1'b1, 1'b0, '0);
    // The drop flag must have cleared with the end of that run.
    dir_row(LIST_B, 32'sd0, 1'b1, 1'b1, '{32'sd0, 1'b1, 1'b0});

    foreach (rows[k]) send_row(rows[k]);

    // Random runs: mostly sorted lists, some overflowing, some unsorted noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      noise   = ($urandom_range(0, 5) == 0);
      wide    = 1'($urandom_range(0, 1));
      cap     = ($urandom_range(0, 7) == 0) ? 12 : DEPTH;
      na      = $urandom_range(0, cap);
      nb      = $urandom_range(0, cap);
      if (na + nb == 0) na = 1;
      qa.delete();
      qb.delete();
      repeat (na) qa.push_back(pick_value(wide));
      repeat (nb) qb.push_back(pick_value(wide));
      if (!noise) begin
        qa.sort();
        qb.sort();
      end
      while (qa.size() + qb.size() > 0) begin
        if (qa.size() == 0) begin
          r.sel = LIST_B;
        end else if (qb.size() == 0) begin
          r.sel = LIST_A;
        end else begin
          r.sel = 1'($urandom_range(0, 1));
        end
        r.value = (r.sel == LIST_A) ? qa.pop_front() : qb.pop_front();
        r.fin   = (qa.size() + qb.size() == 0);
        r.typed = 1'b0;
        r.want  = '0;
        send_row(r);
        sent++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (merged_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    foreach (merged_due[k])
      flag_mismatch($sformatf("result %0d never arrived", merged_due[k].value));

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
